FILE: hw/rtl/nodt_pkg.sv
// Shared types and constants for the nibble-coded identifier to dotted text block.
package nodt_pkg;

  localparam int DIGIT_SLOTS = 10;
  localparam int DIG_IW      = $clog2(DIGIT_SLOTS);
  localparam int BCD_W       = DIGIT_SLOTS * 4;

  localparam logic [3:0] SYM_SHORT_LO = 4'd1;
  localparam logic [3:0] SYM_SHORT_HI = 4'd10;
  localparam logic [3:0] SYM_LONG_LO  = 4'd11;
  localparam logic [3:0] SYM_LONG_HI  = 4'd14;
  localparam logic [3:0] SYM_LONG_BASE = 4'd10;
  localparam logic [3:0] MAX_NIBBLES  = 4'd8;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  // One unit of work for the back end: an arc to print or an end-only marker
  typedef struct packed {
    logic        is_arc;
    logic [31:0] val;
    logic [3:0]  ncnt;      // nibbles in val, 1 for a short arc
    logic        dot;
    logic        run_last;
    logic        text_end;
    logic        truncated;
  } ent_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_LEAD,
    B_DOT,
    B_DIG,
    B_MARK
  } back_st_t;

endpackage

FILE: hw/rtl/nodt_front.sv
// Front end: accepts code bytes, decodes both nibbles and queues arc jobs.
module nodt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_code_byte,
  input  logic               in_final_byte,
  output logic               q_push,
  output nodt_pkg::ent_t     q_ent,
  input  logic               q_full
);

  logic [31:0]    acc_r, acc_nxt;
  logic [3:0]     nl_r, nl_nxt;
  logic [3:0]     ncnt_r, ncnt_nxt;
  logic           stop_r, stop_nxt;
  logic           first_r, first_nxt;
  logic           pend_r;
  nodt_pkg::ent_t pend_ent_r;

  nodt_pkg::ent_t e0, e1;
  logic [1:0]     n_ent;
  logic           accept;

  assign in_stall = pend_r || q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic [3:0]     s;
    logic [3:0]     t;
    nodt_pkg::ent_t arc;
    logic           have_arc;
    acc_nxt   = acc_r;
    nl_nxt    = nl_r;
    ncnt_nxt  = ncnt_r;
    stop_nxt  = stop_r;
    first_nxt = first_r;
    e0        = '0;
    e1        = '0;
    n_ent     = 2'd0;
    for (int k = 0; k < 2; k++) begin
      s        = (k == 0) ? in_code_byte[3:0] : in_code_byte[7:4];
      arc      = '0;
      have_arc = 1'b0;
      t        = s - nodt_pkg::SYM_LONG_BASE;
      if (!stop_nxt) begin
        if (nl_nxt != 4'd0) begin
          acc_nxt = {acc_nxt[27:0], s};
          nl_nxt  = nl_nxt - 4'd1;
          if (nl_nxt == 4'd0) begin
            have_arc = 1'b1;
            arc.val  = acc_nxt;
            arc.ncnt = ncnt_nxt;
          end
        end else if (s inside {[nodt_pkg::SYM_SHORT_LO:nodt_pkg::SYM_SHORT_HI]}) begin
          have_arc = 1'b1;
          arc.val  = {28'd0, s - 4'd1};
          arc.ncnt = 4'd1;
        end else if (s inside {[nodt_pkg::SYM_LONG_LO:nodt_pkg::SYM_LONG_HI]}) begin
          nl_nxt   = {t[2:0], 1'b0};
          ncnt_nxt = {t[2:0], 1'b0};
          acc_nxt  = 32'd0;
        end else begin
          stop_nxt = 1'b1;
        end
      end
      if (have_arc) begin
        arc.is_arc = 1'b1;
        arc.dot    = !first_nxt;
        first_nxt  = 1'b0;
        if (n_ent == 2'd0) begin
          e0 = arc;
        end else begin
          e1 = arc;
        end
        n_ent = n_ent + 2'd1;
      end
    end

    // final byte with nothing printed still owes an end marker
    if (in_final_byte && n_ent == 2'd0) begin
      n_ent = 2'd1;
    end
    if (n_ent == 2'd1) begin
      e0.run_last  = 1'b1;
      e0.text_end  = in_final_byte;
      e0.truncated = in_final_byte && (nl_nxt != 4'd0);
    end else if (n_ent == 2'd2) begin
      e1.run_last  = 1'b1;
      e1.text_end  = in_final_byte;
      e1.truncated = in_final_byte && (nl_nxt != 4'd0);
    end

    if (in_final_byte) begin
      acc_nxt   = 32'd0;
      nl_nxt    = 4'd0;
      stop_nxt  = 1'b0;
      first_nxt = 1'b1;
    end
  end

  assign q_push = (pend_r && !q_full) || (accept && n_ent != 2'd0);
  assign q_ent  = pend_r ? pend_ent_r : e0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 32'd0;
      nl_r    <= 4'd0;
      ncnt_r  <= 4'd0;
      stop_r  <= 1'b0;
      first_r <= 1'b1;
      pend_r  <= 1'b0;
    end else begin
      if (accept) begin
        acc_r   <= acc_nxt;
        nl_r    <= nl_nxt;
        ncnt_r  <= ncnt_nxt;
        stop_r  <= stop_nxt;
        first_r <= first_nxt;
        pend_r  <= (n_ent == 2'd2);
      end else if (pend_r && !q_full) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_ent_r <= e1;
    end
  end

endmodule

FILE: hw/rtl/nodt_queue.sv
// Small FIFO of arc jobs between front and back end.
module nodt_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nodt_pkg::ent_t push_ent,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output nodt_pkg::ent_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  nodt_pkg::ent_t mem_r [DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_ent;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue underflow");

endmodule

FILE: hw/rtl/nodt_back.sv
// Back end: converts arcs to decimal digits and streams characters out.
module nodt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  nodt_pkg::ent_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_ch,
  output logic           out_has_char,
  output logic           out_run_last,
  output logic           out_text_end,
  output logic           out_truncated
);

  localparam int BW = nodt_pkg::BCD_W;
  localparam int IW = nodt_pkg::DIG_IW;

  nodt_pkg::back_st_t state_r, state_nxt;

  logic           dot_r, dot_nxt;
  logic           rl_r, rl_nxt;
  logic           te_r, te_nxt;
  logic           tr_r, tr_nxt;
  logic [BW-1:0]  bcd_r, bcd_nxt;      // decimal digit store
  logic [31:0]    sh_r, sh_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic [IW-1:0]  lead;

  logic           ov_r, ov_nxt;
  logic [7:0]     ch_r, ch_nxt;
  logic           hc_r, hc_nxt;
  logic           orl_r, orl_nxt;
  logic           ote_r, ote_nxt;
  logic           otr_r, otr_nxt;
  logic           emit_ok;
  logic [2:0]     skip;

  // shift one nibble into the BCD digits, four double-dabble steps
  function automatic logic [BW-1:0] dabble4(input logic [BW-1:0] d, input logic [3:0] nib);
    logic [BW-1:0] t;
    t = d;
    for (int b = 3; b >= 0; b--) begin
      for (int i = 0; i < nodt_pkg::DIGIT_SLOTS; i++) begin
        if (t[i*4 +: 4] >= 4'd5) begin
          t[i*4 +: 4] = t[i*4 +: 4] + 4'd3;
        end
      end
      t = {t[BW-2:0], nib[b]};
    end
    return t;
  endfunction

  always_comb begin
    lead = '0;
    for (int i = 0; i < nodt_pkg::DIGIT_SLOTS; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        lead = IW'(i);
      end
    end
  end

  assign emit_ok = !ov_r || !out_stall;
  assign skip    = 3'(nodt_pkg::MAX_NIBBLES - q_head.ncnt);

  always_comb begin
    state_nxt = state_r;
    dot_nxt   = dot_r;
    rl_nxt    = rl_r;
    te_nxt    = te_r;
    tr_nxt    = tr_r;
    bcd_nxt   = bcd_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r && out_stall;
    ch_nxt    = ch_r;
    hc_nxt    = hc_r;
    orl_nxt   = orl_r;
    ote_nxt   = ote_r;
    otr_nxt   = otr_r;
    q_pop     = 1'b0;
    case (state_r)
      nodt_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          dot_nxt = q_head.dot;
          rl_nxt  = q_head.run_last;
          te_nxt  = q_head.text_end;
          tr_nxt  = q_head.truncated;
          if (!q_head.is_arc) begin
            state_nxt = nodt_pkg::B_MARK;
          end else if (q_head.ncnt == 4'd1) begin
            bcd_nxt   = {{(BW-4){1'b0}}, q_head.val[3:0]};
            state_nxt = nodt_pkg::B_LEAD;
          end else begin
            bcd_nxt   = '0;
            sh_nxt    = q_head.val << {skip, 2'b00};
            cnt_nxt   = q_head.ncnt;
            state_nxt = nodt_pkg::B_CONV;
          end
        end
      end
      nodt_pkg::B_CONV: begin
        bcd_nxt = dabble4(bcd_r, sh_r[31:28]);
        sh_nxt  = {sh_r[27:0], 4'd0};
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          state_nxt = nodt_pkg::B_LEAD;
        end
      end
      nodt_pkg::B_LEAD: begin
        idx_nxt   = lead;
        state_nxt = dot_r ? nodt_pkg::B_DOT : nodt_pkg::B_DIG;
      end
      nodt_pkg::B_DOT: begin
        if (emit_ok) begin
          ov_nxt    = 1'b1;
          ch_nxt    = nodt_pkg::CH_DOT;
          hc_nxt    = 1'b1;
          orl_nxt   = 1'b0;
          ote_nxt   = 1'b0;
          otr_nxt   = 1'b0;
          state_nxt = nodt_pkg::B_DIG;
        end
      end
      nodt_pkg::B_DIG: begin
        if (emit_ok) begin
          ov_nxt  = 1'b1;
          ch_nxt  = nodt_pkg::CH_ZERO + {4'd0, bcd_r[{idx_r, 2'b00} +: 4]};
          hc_nxt  = 1'b1;
          orl_nxt = 1'b0;
          ote_nxt = 1'b0;
          otr_nxt = 1'b0;
          if (idx_r == '0) begin
            orl_nxt   = rl_r;
            ote_nxt   = te_r;
            otr_nxt   = tr_r;
            state_nxt = nodt_pkg::B_IDLE;
          end else begin
            idx_nxt = idx_r - IW'(1);
          end
        end
      end
      nodt_pkg::B_MARK: begin
        if (emit_ok) begin
          ov_nxt    = 1'b1;
          ch_nxt    = 8'd0;
          hc_nxt    = 1'b0;
          orl_nxt   = rl_r;
          ote_nxt   = te_r;
          otr_nxt   = tr_r;
          state_nxt = nodt_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = nodt_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nodt_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dot_r <= dot_nxt;
    rl_r  <= rl_nxt;
    te_r  <= te_nxt;
    tr_r  <= tr_nxt;
    bcd_r <= bcd_nxt;
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;
    ch_r  <= ch_nxt;
    hc_r  <= hc_nxt;
    orl_r <= orl_nxt;
    ote_r <= ote_nxt;
    otr_r <= otr_nxt;
  end

  assign out_valid     = ov_r;
  assign out_ch        = ch_r;
  assign out_has_char  = hc_r;
  assign out_run_last  = orl_r;
  assign out_text_end  = ote_r;
  assign out_truncated = otr_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !hc_r |-> ote_r && orl_r)
    else $error("end marker without end flags");
  assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (ote_r || otr_r) |-> orl_r)
    else $error("end flags off the last character of a byte");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nodt_pkg::B_CONV |-> cnt_r != 4'd0)
    else $error("conversion with no nibbles left");

endmodule

FILE: hw/rtl/nibble_oid_to_dotted_text.sv
// Top level: nibble-coded object identifier bytes in, dotted decimal ASCII out.
// Input channel: one code byte per transaction, low nibble decoded first;
// in_final_byte closes the identifier and the next byte starts a new one.
// Output channel: one character per transaction (digit or '.'), or an end-only
// marker (has_char 0) when a final byte printed nothing. run_last tags the last
// character caused by a byte, text_end and truncated the end of the identifier.
// The front end decodes a whole byte in its accept cycle and queues up to two
// arc jobs; it stalls only while the job queue is full or a second job waits.
// The back end takes one job at a time: it pops the job, converts a long arc
// (2 to 8 nibbles) to decimal one nibble per cycle, finds the leading digit,
// then registers one character per cycle unless out_stall holds it; a short
// arc skips the conversion.
// The output register holds its transaction while out_stall is high; the back
// end waits and the queue keeps absorbing bytes. Reset (rst_n low, synchronous)
// empties the queue and returns the decoder to the start of an identifier.
module nibble_oid_to_dotted_text #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_code_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_ch,
  output logic       out_has_char,
  output logic       out_run_last,
  output logic       out_text_end,
  output logic       out_truncated
);

  logic           q_push, q_full, q_pop, q_empty;
  nodt_pkg::ent_t q_ent, q_head;

  nodt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_byte  (in_code_byte),
    .in_final_byte (in_final_byte),
    .q_push        (q_push),
    .q_ent         (q_ent),
    .q_full        (q_full)
  );

  nodt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_ent),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  nodt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ch        (out_ch),
    .out_has_char  (out_has_char),
    .out_run_last  (out_run_last),
    .out_text_end  (out_text_end),
    .out_truncated (out_truncated)
  );

endmodule
